>>> rtl/gape_pkg.sv
// ----------------------------------------------------------------------------
// gape_pkg
// Shared types and constants of the glyph atlas pixel expander.
// ----------------------------------------------------------------------------
package gape_pkg;

  // atlas geometry that does not vary
  localparam int unsigned CellsPerSide = 16;
  localparam int unsigned AddrW        = 16;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  // result of checking one pixel position
  typedef struct packed {
    logic             hit;
    logic [AddrW-1:0] addr;
  } pixel_t;

endpackage

>>> rtl/gape_base_unit.sv
// ----------------------------------------------------------------------------
// gape_base_unit
// Registers the linear address of pixel 0 of a glyph row at input transfer.
// ----------------------------------------------------------------------------
module gape_base_unit #(
  parameter int unsigned CELL_SIZE = 16,
  parameter int unsigned ADDR_W    = 18
) (
  input  logic              clk_i,
  input  logic              load_i,
  input  logic [7:0]        glyph_code_i,
  input  logic [4:0]        x_origin_i,
  input  logic [4:0]        y_origin_i,
  input  logic [3:0]        row_index_i,
  input  logic [4:0]        baseline_i,
  output logic [ADDR_W-1:0] base_o
);

  localparam int unsigned Stride = gape_pkg::CellsPerSide * CELL_SIZE;

  logic [ADDR_W-1:0] atlas_row;
  logic [ADDR_W-1:0] atlas_col;
  logic [ADDR_W-1:0] base_d;
  logic [ADDR_W-1:0] base_q;

  // cell row and column from the code, then row * stride + column
  always_comb begin
    atlas_row = {{(ADDR_W-4){1'b0}}, glyph_code_i[7:4]} * ADDR_W'(CELL_SIZE)
              + {{(ADDR_W-4){1'b0}}, row_index_i}
              + {{(ADDR_W-5){baseline_i[4]}}, baseline_i}
              - {{(ADDR_W-5){y_origin_i[4]}}, y_origin_i};
    atlas_col = {{(ADDR_W-4){1'b0}}, glyph_code_i[3:0]} * ADDR_W'(CELL_SIZE)
              - {{(ADDR_W-5){x_origin_i[4]}}, x_origin_i};
    base_d    = atlas_row * ADDR_W'(Stride) + atlas_col;
  end

  // base register, loaded once per row
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      base_q <= base_d;
    end
  end

  assign base_o = base_q;

endmodule

>>> rtl/gape_pixel_unit.sv
// ----------------------------------------------------------------------------
// gape_pixel_unit
// Shared adder and range compare, stepped over the pixels of one row.
// ----------------------------------------------------------------------------
module gape_pixel_unit #(
  parameter int unsigned CELL_SIZE = 16,
  parameter int unsigned ADDR_W    = 18
) (
  input  logic [ADDR_W-1:0] base_i,
  input  logic [3:0]        pixel_i,
  input  logic [3:0]        glyph_width_i,
  input  logic [15:0]       row_bits_i,
  output gape_pkg::pixel_t  result_o
);

  localparam int unsigned Stride   = gape_pkg::CellsPerSide * CELL_SIZE;
  localparam int unsigned RawLimit = Stride * Stride;
  localparam int unsigned Limit    = (RawLimit > 65536) ? 65536 : RawLimit;

  logic [ADDR_W-1:0] addr;
  logic              ink;
  logic              in_range;

  // bit 15 is pixel 0
  assign ink = row_bits_i[~pixel_i] && (pixel_i < glyph_width_i);

  // candidate address and atlas bounds
  always_comb begin
    addr     = base_i + {{(ADDR_W-4){1'b0}}, pixel_i};
    in_range = !addr[ADDR_W-1] && ($signed(addr) < $signed(ADDR_W'(Limit)));
  end

  assign result_o.hit  = ink && in_range;
  assign result_o.addr = addr[gape_pkg::AddrW-1:0];

endmodule

>>> rtl/glyph_atlas_pixel_expander_core.sv
// ----------------------------------------------------------------------------
// glyph_atlas_pixel_expander_core
// Expands one-bit glyph rows into byte addresses of a square font atlas.
// ----------------------------------------------------------------------------
// Each input transfer carries one glyph row; the block emits one atlas address
// (to be written with 255) for every inked pixel inside glyph_width that lands
// within the atlas, left to right, with last_pixel_o on the final one. A row
// occupies the block from acceptance through a check of each pixel position
// below glyph_width_i, an end-of-scan step and a flush step, plus any time
// the output stalls; in_stall_o is high from the scan until idle. A single
// adder and bounds compare step over the pixel positions one per cycle unless
// the output stalls; the row base is registered at acceptance. One address is
// held back in a pending register so the last flag is known before it leaves.
// ----------------------------------------------------------------------------
module glyph_atlas_pixel_expander_core #(
  parameter int unsigned CELL_SIZE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  glyph_code_i,
  input  logic [3:0]  glyph_width_i,
  input  logic [4:0]  x_origin_i,
  input  logic [4:0]  y_origin_i,
  input  logic [3:0]  row_index_i,
  input  logic [15:0] row_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] pixel_address_o,
  output logic        last_pixel_o
);

  localparam int unsigned Stride = gape_pkg::CellsPerSide * CELL_SIZE;
  localparam int unsigned MaxRow = 15 * CELL_SIZE + 46;
  localparam int unsigned MaxAbs = MaxRow * Stride + 16 * CELL_SIZE + 16;
  localparam int unsigned RawW   = $clog2(MaxAbs + 1) + 1;
  localparam int unsigned ADDR_W = (RawW > 17) ? RawW : 17;

  gape_pkg::state_e  state_d, state_q;
  gape_pkg::pixel_t  pix;
  logic [4:0]        baseline_q;
  logic [3:0]        x_d, x_q;
  logic [3:0]        width_d, width_q;
  logic [15:0]       bits_d, bits_q;
  logic              pend_valid_d, pend_valid_q;
  logic [15:0]       pend_addr_d, pend_addr_q;
  logic              out_valid_d, out_valid_q;
  logic [15:0]       out_addr_d, out_addr_q;
  logic              out_last_d, out_last_q;
  logic [ADDR_W-1:0] base;
  logic              in_xfer;
  logic              out_free;

  assign in_stall_o = (state_q != gape_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // baseline register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q <= '0;
    end else if (cfg_we_i) begin
      baseline_q <= cfg_wdata_i;
    end
  end

  // row base address
  gape_base_unit #(
    .CELL_SIZE (CELL_SIZE),
    .ADDR_W    (ADDR_W)
  ) u_base (
    .clk_i        (clk_i),
    .load_i       (in_xfer),
    .glyph_code_i (glyph_code_i),
    .x_origin_i   (x_origin_i),
    .y_origin_i   (y_origin_i),
    .row_index_i  (row_index_i),
    .baseline_i   (baseline_q),
    .base_o       (base)
  );

  // shared pixel adder and bounds check
  gape_pixel_unit #(
    .CELL_SIZE (CELL_SIZE),
    .ADDR_W    (ADDR_W)
  ) u_pixel (
    .base_i        (base),
    .pixel_i       (x_q),
    .glyph_width_i (width_q),
    .row_bits_i    (bits_q),
    .result_o      (pix)
  );

  // sequencer next state and datapath control
  always_comb begin
    state_d      = state_q;
    x_d          = x_q;
    width_d      = width_q;
    bits_d       = bits_q;
    pend_valid_d = pend_valid_q;
    pend_addr_d  = pend_addr_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_addr_d   = out_addr_q;
    out_last_d   = out_last_q;
    case (state_q)
      gape_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = gape_pkg::ST_SCAN;
          x_d     = '0;
          width_d = glyph_width_i;
          bits_d  = row_bits_i;
        end
      end
      gape_pkg::ST_SCAN: begin
        if (x_q >= width_q) begin
          state_d = gape_pkg::ST_FLUSH;
        end else if (!pix.hit) begin
          x_d = 4'(x_q + 4'd1);
        end else if (!pend_valid_q) begin
          pend_valid_d = 1'b1;
          pend_addr_d  = pix.addr;
          x_d          = 4'(x_q + 4'd1);
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_addr_d  = pend_addr_q;
          out_last_d  = 1'b0;
          pend_addr_d = pix.addr;
          x_d         = 4'(x_q + 4'd1);
        end
      end
      gape_pkg::ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = gape_pkg::ST_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_addr_d   = pend_addr_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = gape_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gape_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= gape_pkg::ST_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      x_q          <= '0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      x_q          <= x_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    width_q     <= width_d;
    bits_q      <= bits_d;
    pend_addr_q <= pend_addr_d;
    out_addr_q  <= out_addr_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_address_o = out_addr_q;
  assign last_pixel_o    = out_last_q;

  // a held address is never left behind when the row ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gape_pkg::ST_IDLE) |-> !pend_valid_q)
    else $error("pending address left over in idle");

  // a non-final address on the output means the row is still in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> (state_q != gape_pkg::ST_IDLE))
    else $error("row ended without a last address");

  // an accepted row starts the scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == gape_pkg::ST_SCAN) && (x_q == '0))
    else $error("accepted row did not start scanning");

  // the scan holds its position while the output path is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gape_pkg::ST_SCAN && x_q < width_q && pix.hit && pend_valid_q
     && out_valid_q && out_stall_i) |=> $stable(x_q))
    else $error("scan advanced while output blocked");

endmodule

>>> test/gape_pixel_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gape_pixel_checker
// Watches both channels of the glyph atlas pixel expander and scores results.
// ----------------------------------------------------------------------------
// Every accepted glyph row is expanded here into the atlas addresses it must
// produce, in order, with the last flag on the final one. Every accepted
// pixel transfer is compared field by field with the oldest of those. The
// baseline register is tracked from the configuration port.
// ----------------------------------------------------------------------------
module gape_pixel_checker #(
  parameter int unsigned CELL_SIZE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  glyph_code_i,
  input  logic [3:0]  glyph_width_i,
  input  logic [4:0]  x_origin_i,
  input  logic [4:0]  y_origin_i,
  input  logic [3:0]  row_index_i,
  input  logic [15:0] row_bits_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] pixel_address_i,
  input  logic        last_pixel_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    logic [gape_pkg::AddrW-1:0] addr;
    logic                       last;
  } atlas_pixel_t;

  localparam int Stride    = gape_pkg::CellsPerSide * CELL_SIZE;
  localparam int AtlasSize = (Stride * Stride > 65536) ? 65536 : Stride * Stride;

  atlas_pixel_t expected_pixels[$];
  logic [4:0]   baseline_q;
  int           fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = expected_pixels.size();

  initial fail_count = 0;

  // one line per mismatch, counted
  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  // inked pixels of one row that land inside the atlas, left to right
  function automatic void expand_row(input logic [7:0] code, input logic [3:0] width,
                                     input logic [4:0] x_org, input logic [4:0] y_org,
                                     input logic [3:0] row, input logic [15:0] bits,
                                     input logic [4:0] baseline);
    atlas_pixel_t row_pixels[$];
    atlas_pixel_t pix;
    int           x_s;
    int           y_s;
    int           base_s;
    int           atlas_row;
    int           col0;
    int           addr;
    x_s       = $signed(x_org);
    y_s       = $signed(y_org);
    base_s    = $signed(baseline);
    atlas_row = int'(code / gape_pkg::CellsPerSide) * CELL_SIZE + int'(row) + base_s - y_s;
    col0      = int'(code % gape_pkg::CellsPerSide) * CELL_SIZE - x_s;
    for (int x = 0; x < int'(width); x++) begin
      if (bits[15-x]) begin
        addr = atlas_row * Stride + col0 + x;
        if (addr >= 0 && addr < AtlasSize) begin
          pix.addr = addr[gape_pkg::AddrW-1:0];
          pix.last = 1'b0;
          row_pixels.push_back(pix);
        end
      end
    end
    if (row_pixels.size() > 0) row_pixels[row_pixels.size()-1].last = 1'b1;
    foreach (row_pixels[i]) expected_pixels.push_back(row_pixels[i]);
  endfunction

  // score pixel transfers, then expand the row transfer of this edge
  always @(posedge clk_i or negedge rst_ni) begin
    atlas_pixel_t exp_pix;
    if (!rst_ni) begin
      baseline_q <= '0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("pixel %h with nothing expected", pixel_address_i));
        end else begin
          exp_pix = expected_pixels.pop_front();
          if (pixel_address_i !== exp_pix.addr)
            report_mismatch($sformatf("pixel_address %h, expected %h",
                                      pixel_address_i, exp_pix.addr));
          if (last_pixel_i !== exp_pix.last)
            report_mismatch($sformatf("last_pixel %b, expected %b at address %h",
                                      last_pixel_i, exp_pix.last, exp_pix.addr));
        end
      end
      if (in_valid_i && !in_stall_i)
        expand_row(glyph_code_i, glyph_width_i, x_origin_i, y_origin_i,
                   row_index_i, row_bits_i, baseline_q);
      if (cfg_we_i) baseline_q <= cfg_wdata_i;
    end
  end

endmodule

>>> test/tb_glyph_atlas_pixel_expander_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_glyph_atlas_pixel_expander_core
// Stimulus and verdict for the glyph atlas pixel expander.
// ----------------------------------------------------------------------------
// A directed set of glyph rows covers the field extremes, rows dropped off
// either end of the atlas, columns wrapping into neighbor rows, bits past
// the width and empty rows. Random rows follow under several baseline
// settings, with random idle bursts on both channels except in the last
// phase. Scoring is done by the checker instance.
// ----------------------------------------------------------------------------
module tb_glyph_atlas_pixel_expander_core;

  localparam int unsigned CellSize   = 16;
  localparam int          SettleCycs = 24;
  localparam int          PhaseRows  = 28;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  glyph_code = '0;
  logic [3:0]  glyph_width = '0;
  logic [4:0]  x_origin = '0;
  logic [4:0]  y_origin = '0;
  logic [3:0]  row_index = '0;
  logic [15:0] row_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] pixel_address;
  logic        last_pixel;
  logic        calm = 1'b0;
  int          stall_left = 0;
  int          fail_count;
  int          pending;

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  glyph_atlas_pixel_expander_core #(
    .CELL_SIZE(CellSize)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .glyph_code_i   (glyph_code),
    .glyph_width_i  (glyph_width),
    .x_origin_i     (x_origin),
    .y_origin_i     (y_origin),
    .row_index_i    (row_index),
    .row_bits_i     (row_bits),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pixel_address_o(pixel_address),
    .last_pixel_o   (last_pixel)
  );

  gape_pixel_checker #(
    .CELL_SIZE(CellSize)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .glyph_code_i   (glyph_code),
    .glyph_width_i  (glyph_width),
    .x_origin_i     (x_origin),
    .y_origin_i     (y_origin),
    .row_index_i    (row_index),
    .row_bits_i     (row_bits),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .pixel_address_i(pixel_address),
    .last_pixel_i   (last_pixel),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // output stall in random bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // one row transfer, sometimes with a random idle burst ahead of it outside the calm phase
  task automatic send_row(input logic [7:0] code, input logic [3:0] width,
                          input logic [4:0] x_org, input logic [4:0] y_org,
                          input logic [3:0] row, input logic [15:0] bits);
    logic taken;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    glyph_code  <= code;
    glyph_width <= width;
    x_origin    <= x_org;
    y_origin    <= y_org;
    row_index   <= row;
    row_bits    <= bits;
    // stall is sampled mid-cycle, where it holds its value for the next edge
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall;
      @(posedge clk_i);
    end
  endtask

  // random row, mostly wide so that most rows produce pixels
  task automatic send_random_row();
    logic [3:0] width;
    width = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 7)) : 4'($urandom_range(8, 15));
    send_row(8'($urandom), width, 5'($urandom), 5'($urandom), 4'($urandom), 16'($urandom));
  endtask

  // drop valid and wait until the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycs) @(posedge clk_i);
  endtask

  task automatic write_baseline(input logic [4:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // main sequence
  initial begin
    logic [4:0] settings[5];
    settings = '{5'(-16), 5'd15, 5'($urandom), 5'd0, 5'($urandom)};
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed rows at the reset baseline
    send_row(8'd0,   4'd15, 5'd0,    5'd0,    4'd0,  16'hFFFF);
    send_row(8'd0,   4'd0,  5'd0,    5'd0,    4'd0,  16'hFFFF);
    send_row(8'd17,  4'd15, 5'd0,    5'd0,    4'd3,  16'h0000);
    send_row(8'd33,  4'd4,  5'd0,    5'd0,    4'd2,  16'h0FFF);
    send_row(8'd33,  4'd4,  5'd0,    5'd0,    4'd2,  16'hF000);
    send_row(8'd5,   4'd1,  5'd0,    5'd0,    4'd1,  16'h8000);
    send_row(8'd90,  4'd15, 5'd3,    5'd2,    4'd7,  16'h0002);
    send_row(8'd120, 4'd15, 5'd0,    5'd0,    4'd4,  16'hAAAA);
    send_row(8'd121, 4'd15, 5'd0,    5'd0,    4'd4,  16'h5555);
    send_row(8'd255, 4'd15, 5'(-16), 5'(-16), 4'd15, 16'hFFFF);
    send_row(8'd0,   4'd15, 5'd0,    5'd15,   4'd0,  16'hFFFF);
    send_row(8'd0,   4'd15, 5'd15,   5'd0,    4'd0,  16'hFFFF);
    send_row(8'd0,   4'd15, 5'd15,   5'(-1),  4'd0,  16'hFFFF);
    send_row(8'd15,  4'd15, 5'(-16), 5'd0,    4'd0,  16'hFFFF);
    send_row(8'd0,   4'd10, 5'd5,    5'd0,    4'd0,  16'hFFFF);
    send_row(8'd255, 4'd15, 5'(-10), 5'd0,    4'd15, 16'hFFFF);
    send_row(8'd255, 4'd15, 5'(-10), 5'd0,    4'd15, 16'hF800);
    send_row(8'd255, 4'd15, 5'(-16), 5'd0,    4'd0,  16'hFFFE);
    send_row(8'd128, 4'd15, 5'(-16), 5'd15,   4'd15, 16'h7FFF);
    send_row(8'd64,  4'd8,  5'd15,   5'(-16), 4'd9,  16'hC3C3);

    // random rows under several baselines, the last phase without idling
    foreach (settings[p]) begin
      settle();
      write_baseline(settings[p]);
      if (p == $size(settings) - 1) calm <= 1'b1;
      repeat (PhaseRows) send_random_row();
    end

    settle();
    if (fail_count == 0) begin
      $display("PASS glyph_atlas_pixel_expander_core");
    end else begin
      $display("FAIL glyph_atlas_pixel_expander_core");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("FAIL glyph_atlas_pixel_expander_core");
    $finish;
  end

endmodule
